// ===== rtl/gptc_pkg.sv =====
// Package: shared widths, reset values, codes and command/status types of the turn controller
`default_nettype none
package gptc_pkg;

    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int STEP_W  = 16;
    localparam int BAND_W  = 17;
    localparam int ERR_W   = 18;
    localparam int RATE_W  = 16;
    localparam int SPEED_W = 16;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;
    localparam int MULA_W  = 17;
    localparam int MULB_W  = 33;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int RND_W   = PROD_W - 13;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd0;
    localparam logic [LIM_W-1:0]  SPEED_LIM_RST  = 15'd1608;
    localparam logic [STEP_W-1:0] STEP_SEC_RST   = 16'd2097;
    localparam logic [BAND_W-1:0] DONE_BAND_RST  = 17'd82;

    localparam logic [IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_SEC    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DONE_BAND   = 3'd5;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_ERROR,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_ACCUM,
        ST_SAT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MUL_RATE,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     err_en;
        logic     aux_en;
        logic     sat_en;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_kind;
        logic turning;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/gptc_ctrl.sv =====
// Controller: sequencing state machine and handshake control of the turn controller
`default_nettype none
module gptc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire gptc_pkg::dp_stat_t stat,
    output gptc_pkg::dp_cmd_t      cmd
);

    gptc_pkg::state_t state_reg;
    gptc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gptc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.load_in     = 1'b0;
        cmd.mul_sel     = gptc_pkg::MUL_RATE;
        cmd.acc_op      = gptc_pkg::ACC_HOLD;
        cmd.err_en      = 1'b0;
        cmd.aux_en      = 1'b0;
        cmd.sat_en      = 1'b0;
        cmd.emit        = 1'b0;
        case (state_reg)
            gptc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (stat.in_kind == gptc_pkg::KIND_START || !stat.turning)
                    begin
                        state_next = gptc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = gptc_pkg::ST_RATE;
                    end
                end
            end
            gptc_pkg::ST_RATE:
            begin
                cmd.mul_sel = gptc_pkg::MUL_RATE;
                state_next  = gptc_pkg::ST_ERROR;
            end
            gptc_pkg::ST_ERROR:
            begin
                cmd.err_en = 1'b1;
                state_next = gptc_pkg::ST_PROP;
            end
            gptc_pkg::ST_PROP:
            begin
                cmd.mul_sel = gptc_pkg::MUL_PROP;
                cmd.aux_en  = 1'b1;
                state_next  = gptc_pkg::ST_INTEG;
            end
            gptc_pkg::ST_INTEG:
            begin
                cmd.mul_sel = gptc_pkg::MUL_INTEG;
                cmd.acc_op  = gptc_pkg::ACC_LOAD;
                state_next  = gptc_pkg::ST_DERIV;
            end
            gptc_pkg::ST_DERIV:
            begin
                cmd.mul_sel = gptc_pkg::MUL_DERIV;
                cmd.acc_op  = gptc_pkg::ACC_ADD;
                state_next  = gptc_pkg::ST_ACCUM;
            end
            gptc_pkg::ST_ACCUM:
            begin
                cmd.acc_op = gptc_pkg::ACC_ADD;
                state_next = gptc_pkg::ST_SAT;
            end
            gptc_pkg::ST_SAT:
            begin
                cmd.sat_en = 1'b1;
                state_next = gptc_pkg::ST_EMIT;
            end
            gptc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gptc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gptc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != gptc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/gptc_datapath.sv =====
// Datapath: configuration registers, turn state, shared multiplier, accumulator and result registers
`default_nettype none
module gptc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [gptc_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [gptc_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                kind,
    input  wire logic signed [gptc_pkg::ERR_W-1:0]   target_angle,
    input  wire logic signed [gptc_pkg::RATE_W-1:0]  gyro_rate,
    input  wire gptc_pkg::dp_cmd_t                   cmd,
    output gptc_pkg::dp_stat_t                       stat,
    output logic signed [gptc_pkg::SPEED_W-1:0]      left_speed,
    output logic signed [gptc_pkg::SPEED_W-1:0]      right_speed,
    output logic                                     busy_res,
    output logic                                     finished
);

    localparam int ERR_W  = gptc_pkg::ERR_W;
    localparam int SUM_W  = gptc_pkg::SUM_W;
    localparam int DIFF_W = gptc_pkg::DIFF_W;
    localparam int PROD_W = gptc_pkg::PROD_W;
    localparam int RND_W  = gptc_pkg::RND_W;
    localparam int SPD_W  = gptc_pkg::SPEED_W;

    logic [gptc_pkg::GAIN_W-1:0] gain_prop_reg;
    logic [gptc_pkg::GAIN_W-1:0] gain_integ_reg;
    logic [gptc_pkg::GAIN_W-1:0] gain_deriv_reg;
    logic [gptc_pkg::LIM_W-1:0]  speed_limit_reg;
    logic [gptc_pkg::STEP_W-1:0] step_sec_reg;
    logic [gptc_pkg::BAND_W-1:0] done_band_reg;

    logic signed [ERR_W-1:0] rem_err_reg;
    logic signed [ERR_W-1:0] last_err_reg;
    logic signed [SUM_W-1:0] err_sum_reg;
    logic                    turning_reg;

    logic                               kind_reg;
    logic signed [ERR_W-1:0]            target_reg;
    logic signed [gptc_pkg::RATE_W-1:0] rate_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [SUM_W-1:0]  sum_new_reg;
    logic signed [SUM_W-1:0]  sum_new_next;
    logic signed [DIFF_W-1:0] delta_reg;
    logic signed [SPD_W-1:0]  u_reg;
    logic signed [SPD_W-1:0]  u_next;

    logic signed [SPD_W-1:0] left_reg;
    logic signed [SPD_W-1:0] right_reg;
    logic                    busy_reg;
    logic                    fin_reg;

    logic signed [gptc_pkg::MULA_W-1:0] mul_a;
    logic signed [gptc_pkg::MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           turned_full;
    logic signed [ERR_W-1:0]            turned;
    logic signed [DIFF_W-1:0]           err_diff;
    logic signed [SUM_W:0]              sum_wide;
    logic signed [PROD_W-1:0]           acc_rnd;
    logic signed [RND_W-1:0]            u_wide;
    logic signed [RND_W-1:0]            lim_pos;
    logic signed [RND_W-1:0]            lim_neg;
    logic [ERR_W-1:0]                   err_mag;
    logic                               in_band;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= gptc_pkg::GAIN_PROP_RST;
            gain_integ_reg  <= gptc_pkg::GAIN_INTEG_RST;
            gain_deriv_reg  <= gptc_pkg::GAIN_DERIV_RST;
            speed_limit_reg <= gptc_pkg::SPEED_LIM_RST;
            step_sec_reg    <= gptc_pkg::STEP_SEC_RST;
            done_band_reg   <= gptc_pkg::DONE_BAND_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gptc_pkg::REG_GAIN_PROP:   gain_prop_reg   <= cfg_data[gptc_pkg::GAIN_W-1:0];
                gptc_pkg::REG_GAIN_INTEG:  gain_integ_reg  <= cfg_data[gptc_pkg::GAIN_W-1:0];
                gptc_pkg::REG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data[gptc_pkg::GAIN_W-1:0];
                gptc_pkg::REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[gptc_pkg::LIM_W-1:0];
                gptc_pkg::REG_STEP_SEC:    step_sec_reg    <= cfg_data[gptc_pkg::STEP_W-1:0];
                gptc_pkg::REG_DONE_BAND:   done_band_reg   <= cfg_data[gptc_pkg::BAND_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            gptc_pkg::MUL_RATE:
            begin
                mul_a = {1'b0, step_sec_reg};
                mul_b = {{17{rate_reg[15]}}, rate_reg};
            end
            gptc_pkg::MUL_PROP:
            begin
                mul_a = {1'b0, gain_prop_reg};
                mul_b = {{15{err_reg[ERR_W-1]}}, err_reg};
            end
            gptc_pkg::MUL_INTEG:
            begin
                mul_a = {1'b0, gain_integ_reg};
                mul_b = {sum_new_reg[SUM_W-1], sum_new_reg};
            end
            gptc_pkg::MUL_DERIV:
            begin
                mul_a = {1'b0, gain_deriv_reg};
                mul_b = {{14{delta_reg[DIFF_W-1]}}, delta_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // turned angle, rounded to Q4.13, and saturated error
    assign turned_full = prod_reg + PROD_W'(16384);
    assign turned      = turned_full[32:15];
    assign err_diff    = {rem_err_reg[ERR_W-1], rem_err_reg} - {turned[ERR_W-1], turned};

    always_comb
    begin
        if (err_diff[DIFF_W-1] != err_diff[DIFF_W-2])
        begin
            err_next = err_diff[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}}
                                          : {1'b0, {(ERR_W-1){1'b1}}};
        end
        else
        begin
            err_next = err_diff[ERR_W-1:0];
        end
    end

    // integral with saturation
    assign sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg}
                    + {{(SUM_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_new_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_new_next = sum_wide[SUM_W-1:0];
        end
    end

    // round PID sum to Q8.8 and clamp to the speed limit
    assign acc_rnd = acc_reg + PROD_W'(4096);
    assign u_wide  = acc_rnd[PROD_W-1:13];
    assign lim_pos = RND_W'({1'b0, speed_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (u_wide > lim_pos)
        begin
            u_next = lim_pos[SPD_W-1:0];
        end
        else if (u_wide < lim_neg)
        begin
            u_next = lim_neg[SPD_W-1:0];
        end
        else
        begin
            u_next = u_wide[SPD_W-1:0];
        end
    end

    assign err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign in_band = (err_mag <= {1'b0, done_band_reg});

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_in)
        begin
            kind_reg   <= kind;
            target_reg <= target_angle;
            rate_reg   <= gyro_rate;
        end
        if (cmd.err_en)
        begin
            err_reg <= err_next;
        end
        if (cmd.aux_en)
        begin
            sum_new_reg <= sum_new_next;
            delta_reg   <= {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};
        end
        case (cmd.acc_op)
            gptc_pkg::ACC_LOAD: acc_reg <= prod_reg;
            gptc_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:
            begin
            end
        endcase
        if (cmd.sat_en)
        begin
            u_reg <= u_next;
        end
    end

    // turn state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_err_reg  <= '0;
            last_err_reg <= '0;
            err_sum_reg  <= '0;
            turning_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            if (kind_reg == gptc_pkg::KIND_START)
            begin
                rem_err_reg  <= target_reg;
                last_err_reg <= target_reg;
                err_sum_reg  <= '0;
                turning_reg  <= 1'b1;
            end
            else if (turning_reg)
            begin
                rem_err_reg  <= err_reg;
                last_err_reg <= err_reg;
                if (in_band)
                begin
                    err_sum_reg <= '0;
                    turning_reg <= 1'b0;
                end
                else
                begin
                    err_sum_reg <= sum_new_reg;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (kind_reg == gptc_pkg::KIND_START)
            begin
                left_reg  <= {1'b0, speed_limit_reg};
                right_reg <= {1'b0, speed_limit_reg};
                busy_reg  <= 1'b1;
                fin_reg   <= 1'b0;
            end
            else if (turning_reg && !in_band)
            begin
                left_reg  <= -u_reg;
                right_reg <= u_reg;
                busy_reg  <= 1'b1;
                fin_reg   <= 1'b0;
            end
            else
            begin
                left_reg  <= '0;
                right_reg <= '0;
                busy_reg  <= 1'b0;
                fin_reg   <= turning_reg;
            end
        end
    end

    assign stat.in_kind = kind;
    assign stat.turning = turning_reg;

    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign busy_res    = busy_reg;
    assign finished    = fin_reg;

endmodule
`default_nettype wire

// ===== rtl/gyro_pid_turn_controller_core.sv =====
// Top level: gyro PID turn controller, controller and datapath joined
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------------------
// in      | input     | in_valid/in_stall   | kind, target_angle, gyro_rate
// out     | output    | out_valid/out_stall | left_speed, right_speed, busy_res, finished
// cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A control tick during a turn steps through rate, error, prop, integ, deriv, accum,
// sat and emit: the multiplier is shared by the turned-angle product and the three
// PID terms. A start item, or a tick while idle, goes to emit. One item at a time.
// Reset restores register defaults and an idle controller; no clearing pass.
// A result held by out_stall blocks the next result, not the next transfer.
`default_nettype none
module gyro_pid_turn_controller_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [gptc_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [gptc_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               kind,
    input  wire logic signed [gptc_pkg::ERR_W-1:0]  target_angle,
    input  wire logic signed [gptc_pkg::RATE_W-1:0] gyro_rate,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [gptc_pkg::SPEED_W-1:0]     left_speed,
    output logic signed [gptc_pkg::SPEED_W-1:0]     right_speed,
    output logic                                    busy_res,
    output logic                                    finished
);

    gptc_pkg::dp_cmd_t  cmd;
    gptc_pkg::dp_stat_t stat;

    gptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gptc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .target_angle (target_angle),
        .gyro_rate    (gyro_rate),
        .cmd          (cmd),
        .stat         (stat),
        .left_speed   (left_speed),
        .right_speed  (right_speed),
        .busy_res     (busy_res),
        .finished     (finished)
    );

endmodule
`default_nettype wire
